FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("property check failed");
// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, ck, rn, prop)
`define ASSERT_NEVER(lbl, ck, rn, cond)
`endif

`endif

FILE: hw/rtl/isp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_pkg
// widths, codes and derived sizes of the interpolating sample player
// ----------------------------------------------------------------------------
package isp_pkg;

    localparam int ADDR_BITS   = 18;
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 16;

    localparam int POS_W   = 40;
    localparam int INT_W   = POS_W - FRAC_BITS;
    localparam int DEPTH   = 1 << ADDR_BITS;
    localparam int MEM_W   = 2 * SAMPLE_BITS;
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;

    // configuration register widths
    localparam int STEP_W  = 20;
    localparam int START_W = 18;
    localparam int END_W   = 19;
    localparam int LLEN_W  = 19;
    localparam int CHAN_W  = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    // width that holds every bound and the memory depth itself
    localparam int BND_W = (ADDR_BITS + 1 > END_W) ? ADDR_BITS + 1 : END_W;
    localparam int CMP_W = (INT_W > BND_W) ? INT_W : BND_W;

    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRIG = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_STEP  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_END   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LLEN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHAN  = 3'd4;

    localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(65536);
    localparam logic [START_W-1:0] START_RST = '0;
    localparam logic [END_W-1:0]   END_RST   = END_W'(262144);
    localparam logic [LLEN_W-1:0]  LLEN_RST  = '0;
    localparam logic [CHAN_W-1:0]  CHAN_RST  = CHAN_W'(2);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [ADDR_BITS-1:0]          frame_addr_t;
    typedef logic [BND_W-1:0]              bound_t;

endpackage

FILE: hw/rtl/isp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_in_if
// input item channel: load, trigger and tick items
// ----------------------------------------------------------------------------
interface isp_in_if
    import isp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    frame_addr_t         frame_address;
    sample_t             left_in;
    sample_t             right_in;

    modport source (output valid, output mode, output frame_address,
                    output left_in, output right_in, input ready);
    modport sink   (input valid, input mode, input frame_address,
                    input left_in, input right_in, output ready);
endinterface

FILE: hw/rtl/isp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_out_if
// result item channel: interpolated frame and voice status
// ----------------------------------------------------------------------------
interface isp_out_if
    import isp_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;
    logic    voice_active;
    logic    region_finished;

    modport source (output valid, output left_out, output right_out,
                    output voice_active, output region_finished, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input voice_active, input region_finished, output ready);
endinterface

FILE: hw/rtl/isp_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface isp_cfg_if
    import isp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: hw/rtl/interpolating_sample_player.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolating_sample_player
// one sampler voice: frame memory, fixed-point play position, linear interp
// ----------------------------------------------------------------------------
//  channel     role   payload
//  sample_in   sink   mode, frame_address, left_in, right_in
//  sample_out  source left_out, right_out, voice_active, region_finished
//  cfg         sink   addr (register index), data
//
//  load item: written straight into the frame memory
//  trigger item: wait and evaluate states; tick item that interpolates: the two
//  neighbor frame reads, one after the other on the single memory port, then
//  difference, multiply, sum; silent or finishing tick: wait and evaluate states
//  region bounds are re-derived from the registers in two registered steps
//  frame memory has no reset; a frame reads as defined only once loaded
//  a tick holds in evaluation while the output register is still full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module interpolating_sample_player
    import isp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    isp_in_if.sink        sample_in,
    isp_out_if.source     sample_out,
    isp_cfg_if.sink       cfg
);

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] S_WAIT = 3'd1;
    localparam logic [STATE_W-1:0] S_EVAL = 3'd2;
    localparam logic [STATE_W-1:0] S_RD2  = 3'd3;
    localparam logic [STATE_W-1:0] S_DIFF = 3'd4;
    localparam logic [STATE_W-1:0] S_MUL  = 3'd5;
    localparam logic [STATE_W-1:0] S_SUM  = 3'd6;

    // configuration
    logic [STEP_W-1:0]  step_reg;
    logic [START_W-1:0] start_cfg_reg;
    logic [END_W-1:0]   end_cfg_reg;
    logic [LLEN_W-1:0]  llen_cfg_reg;
    logic [CHAN_W-1:0]  chan_reg;

    // derived bounds
    bound_t len_reg, last_reg, start_reg, end_reg;
    bound_t len_next, last_next, start_next, end_next;
    bound_t llen_ext, depth_ext, rs_ext, re_ext, lo_c;

    // control
    logic [STATE_W-1:0] state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               playing_reg, playing_next;
    logic               out_valid_reg, out_valid_next;

    // payload
    logic [MODE_W-1:0]    mode_reg;
    frame_addr_t          addr1_reg;
    logic                 edge_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    sample_t              s1_l_reg, s1_r_reg;
    logic signed [DIFF_W-1:0] diff_l_reg, diff_r_reg;
    logic signed [PROD_W-1:0] prod_l_reg, prod_r_reg;
    sample_t              out_l_reg, out_r_reg;
    logic                 out_active_reg, out_fin_reg;

    // frame memory
    logic [MEM_W-1:0] mem [DEPTH];
    logic [MEM_W-1:0] rd_reg;
    logic             mem_we;
    frame_addr_t      mem_addr;

    logic        in_acc, out_free;
    logic        res_load, res_active, res_fin;
    sample_t     res_l, res_r;
    logic [CMP_W-1:0] p_cmp;
    logic        at_edge;
    frame_addr_t addr1_c;
    sample_t     rd_l, rd_r;
    logic signed [PROD_W-1:0] sum_l, sum_r;

    assign in_acc    = sample_in.valid && sample_in.ready;
    assign out_free  = !out_valid_reg || sample_out.ready;
    assign sample_in.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign sample_out.valid           = out_valid_reg;
    assign sample_out.left_out        = out_l_reg;
    assign sample_out.right_out       = out_r_reg;
    assign sample_out.voice_active    = out_active_reg;
    assign sample_out.region_finished = out_fin_reg;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RST;
            start_cfg_reg <= START_RST;
            end_cfg_reg   <= END_RST;
            llen_cfg_reg  <= LLEN_RST;
            chan_reg      <= CHAN_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.addr)
                CFG_STEP:  step_reg      <= cfg.data[STEP_W-1:0];
                CFG_START: start_cfg_reg <= cfg.data[START_W-1:0];
                CFG_END:   end_cfg_reg   <= cfg.data[END_W-1:0];
                CFG_LLEN:  llen_cfg_reg  <= cfg.data[LLEN_W-1:0];
                CFG_CHAN:  chan_reg      <= cfg.data[CHAN_W-1:0];
                default:   ;
            endcase
        end
    end

    // ---------------- bounds, two registered steps ----------------
    always_comb
    begin
        llen_ext  = BND_W'(llen_cfg_reg);
        depth_ext = BND_W'(DEPTH);
        len_next  = (llen_ext > depth_ext) ? depth_ext : llen_ext;
        last_next = (llen_ext > depth_ext) ? depth_ext - 1'b1 : llen_ext - 1'b1;

        rs_ext     = BND_W'(start_cfg_reg);
        re_ext     = BND_W'(end_cfg_reg);
        start_next = (rs_ext > last_reg) ? last_reg : rs_ext;
        // start + 1 equals min(region_start + 1, len) whenever len is nonzero
        lo_c       = (rs_ext + 1'b1 > len_reg) ? len_reg : rs_ext + 1'b1;
        if (re_ext < lo_c)
            end_next = lo_c;
        else if (re_ext > len_reg)
            end_next = len_reg;
        else
            end_next = re_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            last_reg  <= '1;
            start_reg <= '0;
            end_reg   <= '0;
        end
        else
        begin
            len_reg   <= len_next;
            last_reg  <= last_next;
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    // ---------------- frame memory ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= {sample_in.left_in, sample_in.right_in};
        rd_reg <= mem[mem_addr];
    end

    assign rd_l = rd_reg[MEM_W-1:SAMPLE_BITS];
    assign rd_r = rd_reg[SAMPLE_BITS-1:0];

    // ---------------- sequencer ----------------
    assign p_cmp   = CMP_W'(pos_reg[POS_W-1:FRAC_BITS]);
    assign at_edge = (p_cmp >= CMP_W'(last_reg));
    assign addr1_c = at_edge ? last_reg[ADDR_BITS-1:0] : p_cmp[ADDR_BITS-1:0];

    // floor of the scaled product is an arithmetic shift
    assign sum_l = PROD_W'(s1_l_reg) + (prod_l_reg >>> FRAC_BITS);
    assign sum_r = PROD_W'(s1_r_reg) + (prod_r_reg >>> FRAC_BITS);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        playing_next   = playing_reg;
        out_valid_next = out_valid_reg && !sample_out.ready;
        res_load       = 1'b0;
        res_l          = '0;
        res_r          = '0;
        res_active     = playing_reg;
        res_fin        = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = addr1_reg + 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                mem_addr = sample_in.frame_address;
                if (in_acc)
                begin
                    if (sample_in.mode == MODE_LOAD)
                        mem_we = 1'b1;
                    else if (sample_in.mode == MODE_TRIG || sample_in.mode == MODE_TICK)
                        state_next = S_WAIT;
                end
            end
            S_WAIT:
                state_next = S_EVAL;
            S_EVAL:
            begin
                mem_addr = addr1_c;
                if (mode_reg == MODE_TRIG)
                begin
                    if (len_reg != '0)
                    begin
                        pos_next     = POS_W'(start_reg) << FRAC_BITS;
                        playing_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    if (len_reg == '0 || !playing_reg)
                    begin
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (p_cmp >= CMP_W'(end_reg))
                    begin
                        playing_next = 1'b0;
                        res_load     = 1'b1;
                        res_active   = 1'b0;
                        res_fin      = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + POS_W'(step_reg);
                        state_next = S_RD2;
                    end
                end
            end
            S_RD2:
                state_next = S_DIFF;
            S_DIFF:
                state_next = S_MUL;
            S_MUL:
                state_next = S_SUM;
            S_SUM:
            begin
                res_load   = 1'b1;
                res_l      = (chan_reg != '0) ? sum_l[SAMPLE_BITS-1:0] : '0;
                res_r      = (chan_reg >= CHAN_W'(2)) ? sum_r[SAMPLE_BITS-1:0] : '0;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        if (res_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            playing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            playing_reg   <= playing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
            mode_reg <= sample_in.mode;
        if (state_reg == S_EVAL)
        begin
            addr1_reg <= addr1_c;
            edge_reg  <= at_edge;
            frac_reg  <= pos_reg[FRAC_BITS-1:0];
        end
        if (state_reg == S_RD2)
        begin
            s1_l_reg <= rd_l;
            s1_r_reg <= rd_r;
        end
        if (state_reg == S_DIFF)
        begin
            // at or past the last frame the difference is forced to zero, holding that frame
            diff_l_reg <= edge_reg ? '0 : DIFF_W'(rd_l) - DIFF_W'(s1_l_reg);
            diff_r_reg <= edge_reg ? '0 : DIFF_W'(rd_r) - DIFF_W'(s1_r_reg);
        end
        if (state_reg == S_MUL)
        begin
            prod_l_reg <= PROD_W'(diff_l_reg) * PROD_W'($signed({1'b0, frac_reg}));
            prod_r_reg <= PROD_W'(diff_r_reg) * PROD_W'($signed({1'b0, frac_reg}));
        end
        if (res_load)
        begin
            out_l_reg      <= res_l;
            out_r_reg      <= res_r;
            out_active_reg <= res_active;
            out_fin_reg    <= res_fin;
        end
    end

    // ---------------- checks ----------------
    `ASSERT_PROP(a_out_slot_free, clk, rst_n, res_load |-> !out_valid_reg || sample_out.ready)
    `ASSERT_PROP(a_finish_stops, clk, rst_n, res_load && res_fin |=> !playing_reg && !sample_out.voice_active)
    `ASSERT_NEVER(a_write_busy, clk, rst_n, mem_we && state_reg != S_IDLE)

endmodule

FILE: test/interpolating_sample_player_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolating_sample_player_tb
// self-checking bench for the sampler voice: loads frames, plays regions
// under many register settings and compares each tick result against an
// in-bench voice predictor, with random idling on both channels and one
// long output stall that backs up the input
// ----------------------------------------------------------------------------
module interpolating_sample_player_tb;
    import isp_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_CYCLES     = 400;
    localparam int LOADED_FRAMES   = 65;
    localparam int TOP_FRAME       = DEPTH - 1;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 20;
    localparam int RUN_LIMIT_NS    = 3_000_000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        frame_addr_t       addr;
        sample_t           left;
        sample_t           right;
    } player_item_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    active;
        logic    finished;
    } voice_out_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    isp_in_if  in_ch ();
    isp_out_if out_ch ();
    isp_cfg_if cfg_ch ();

    logic                  in_valid  = 1'b0;
    logic [MODE_W-1:0]     in_mode   = MODE_LOAD;
    frame_addr_t           in_addr   = '0;
    sample_t               in_left   = '0;
    sample_t               in_right  = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_STEP;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    assign in_ch.valid         = in_valid;
    assign in_ch.mode          = in_mode;
    assign in_ch.frame_address = in_addr;
    assign in_ch.left_in       = in_left;
    assign in_ch.right_in      = in_right;
    assign out_ch.ready        = out_ready;
    assign cfg_ch.valid        = cfg_valid;
    assign cfg_ch.addr         = cfg_addr;
    assign cfg_ch.data         = cfg_data;

    interpolating_sample_player u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (in_ch),
        .sample_out (out_ch),
        .cfg        (cfg_ch)
    );

    // voice predictor state
    sample_t            frame_left [frame_addr_t];
    sample_t            frame_right [frame_addr_t];
    logic [POS_W-1:0]   play_pos  = '0;
    logic               voice_on  = 1'b0;
    logic [STEP_W-1:0]  step_reg  = STEP_RST;
    logic [START_W-1:0] start_reg = START_RST;
    logic [END_W-1:0]   end_reg   = END_RST;
    logic [LLEN_W-1:0]  llen_reg  = LLEN_RST;
    logic [CHAN_W-1:0]  chan_reg  = CHAN_RST;

    player_item_t item_q [$];
    voice_out_t   expected_out [$];

    logic in_fire  = 1'b0;
    logic out_hold = 1'b0;
    logic hold_go  = 1'b0;
    int   gap_pct   = 0;
    int   stall_pct = 0;

    int mismatch_count = 0;
    int n_checked      = 0;
    int n_ticks        = 0;
    int n_triggers     = 0;
    int n_loads        = 0;
    int n_region_ends  = 0;
    int n_reg_writes   = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint sample_len();
        if (longint'(llen_reg) > longint'(DEPTH))
            return longint'(DEPTH);
        return longint'(llen_reg);
    endfunction

    function automatic longint region_first(longint len);
        if (longint'(start_reg) > len - 1)
            return len - 1;
        return longint'(start_reg);
    endfunction

    function automatic sample_t read_frame(bit right_side, longint idx);
        frame_addr_t a;
        a = frame_addr_t'(idx);
        if (right_side)
            return frame_right[a];
        return frame_left[a];
    endfunction

    // s1 + floor((s2 - s1) * frac / 2^FRAC_BITS); at or past the last frame, hold it
    function automatic sample_t interp_channel(bit right_side, longint len, longint p,
                                               longint frac);
        longint s1;
        longint s2;
        longint part;
        if (p >= len - 1)
            return read_frame(right_side, len - 1);
        s1   = longint'(read_frame(right_side, p));
        s2   = longint'(read_frame(right_side, p + 1));
        part = ((s2 - s1) * frac) >>> FRAC_BITS;
        return sample_t'(s1 + part);
    endfunction

    function automatic void predict_item(player_item_t it);
        voice_out_t res;
        longint     len;
        longint     last;
        longint     p;
        longint     frac;
        len = sample_len();
        res = '0;
        if (it.mode == MODE_LOAD) begin
            frame_left[it.addr]  = it.left;
            frame_right[it.addr] = it.right;
            n_loads++;
            return;
        end
        if (it.mode == MODE_TRIG) begin
            n_triggers++;
            if (len != 0) begin
                play_pos = POS_W'(region_first(len)) << FRAC_BITS;
                voice_on = 1'b1;
            end
            return;
        end
        if (it.mode != MODE_TICK)
            return;
        n_ticks++;
        if (len != 0 && voice_on) begin
            p    = longint'(play_pos[POS_W-1:FRAC_BITS]);
            frac = longint'(play_pos[FRAC_BITS-1:0]);
            last = region_first(len) + 1;
            if (longint'(end_reg) > last)
                last = longint'(end_reg);
            if (last > len)
                last = len;
            if (p >= last) begin
                voice_on     = 1'b0;
                res.finished = 1'b1;
                n_region_ends++;
            end else begin
                if (chan_reg >= 1)
                    res.left = interp_channel(1'b0, len, p, frac);
                if (chan_reg >= 2)
                    res.right = interp_channel(1'b1, len, p, frac);
                play_pos = play_pos + POS_W'(step_reg);
            end
        end
        res.active = voice_on;
        expected_out.push_back(res);
    endfunction

    // result check first, then the item taken at the same edge
    always @(posedge clk) begin : scoreboard
        voice_out_t   want;
        player_item_t got;
        in_fire = in_ch.valid && in_ch.ready;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_out.size() == 0) begin
                $error("result item with no expected result pending");
                mismatch_count++;
            end else begin
                want = expected_out.pop_front();
                n_checked++;
                if (out_ch.left_out !== want.left) begin
                    $error("left_out: expected %0d, got %0d", want.left, out_ch.left_out);
                    mismatch_count++;
                end
                if (out_ch.right_out !== want.right) begin
                    $error("right_out: expected %0d, got %0d", want.right, out_ch.right_out);
                    mismatch_count++;
                end
                if (out_ch.voice_active !== want.active) begin
                    $error("voice_active: expected %0b, got %0b", want.active,
                           out_ch.voice_active);
                    mismatch_count++;
                end
                if (out_ch.region_finished !== want.finished) begin
                    $error("region_finished: expected %0b, got %0b", want.finished,
                           out_ch.region_finished);
                    mismatch_count++;
                end
            end
        end
        if (rst_n && in_fire) begin
            got.mode  = in_ch.mode;
            got.addr  = in_ch.frame_address;
            got.left  = in_ch.left_in;
            got.right = in_ch.right_in;
            predict_item(got);
        end
    end

    always @(negedge clk) begin : item_driver
        player_item_t head_item;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (item_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                head_item = item_q.pop_front();
                in_valid  <= 1'b1;
                in_mode   <= head_item.mode;
                in_addr   <= head_item.addr;
                in_left   <= head_item.left;
                in_right  <= head_item.right;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin : result_sink
        out_ready <= rst_n && !out_hold && ($urandom_range(99) >= stall_pct);
    end

    // long output stall so the voice backs up and stalls its input
    initial begin : long_hold
        wait (hold_go);
        @(negedge clk);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_hold <= 1'b0;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $error("run did not finish in time");
        $display("*** FAILED ***");
        $finish;
    end

    task automatic add_item(logic [MODE_W-1:0] md, frame_addr_t a, sample_t l, sample_t r);
        player_item_t it;
        it.mode  = md;
        it.addr  = a;
        it.left  = l;
        it.right = r;
        item_q.push_back(it);
    endtask

    // mode set, every other field random (ignored unless loading)
    task automatic add_random(logic [MODE_W-1:0] md);
        add_item(md, frame_addr_t'($urandom), sample_t'($urandom), sample_t'($urandom));
    endtask

    task automatic add_ticks(int count);
        repeat (count) add_random(MODE_TICK);
    endtask

    task automatic add_loaded_frame();
        add_item(MODE_LOAD, frame_addr_t'($urandom_range(LOADED_FRAMES - 1)),
                 sample_t'($urandom), sample_t'($urandom));
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            CFG_STEP:  step_reg  = STEP_W'(value);
            CFG_START: start_reg = START_W'(value);
            CFG_END:   end_reg   = END_W'(value);
            CFG_LLEN:  llen_reg  = LLEN_W'(value);
            CFG_CHAN:  chan_reg  = CHAN_W'(value);
            default: ;
        endcase
        n_reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int step, int first, int stop, int len, int chans);
        write_reg(CFG_STEP, step);
        write_reg(CFG_START, first);
        write_reg(CFG_END, stop);
        write_reg(CFG_LLEN, len);
        write_reg(CFG_CHAN, chans);
        @(posedge clk);
    endtask

    // all items taken, all results back, then let the pipeline drain
    task automatic wait_idle();
        while (item_q.size() != 0 || in_valid || expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(int gap, int stall);
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    initial begin : stimulus
        int phase;
        int budget;
        int pick;
        int k;
        int step_v;
        int start_v;
        int end_v;
        int len_v;
        int chan_v;
        bit wide;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty sample: trigger ignored, ticks silent, spare code ignored
        set_idling(15, 15);
        add_ticks(1);
        add_random(MODE_TRIG);
        add_ticks(1);
        add_item(MODE_SPARE, '1, '1, '1);
        // full-scale swings at the bottom of memory, extremes of every field
        add_item(MODE_LOAD, '0, 16'sh7FFF, 16'sh8000);
        add_item(MODE_LOAD, frame_addr_t'(1), 16'sh8000, 16'sh7FFF);
        for (k = 2; k < LOADED_FRAMES; k++)
            add_item(MODE_LOAD, frame_addr_t'(k), sample_t'($urandom), sample_t'($urandom));
        add_item(MODE_LOAD, frame_addr_t'(TOP_FRAME), 16'sh8000, 16'sh7FFF);
        wait_idle();

        // half-frame steps across the swing, channel code three plays stereo
        set_regs(32'h08000, 0, 262144, 16, 3);
        add_random(MODE_TRIG);
        add_ticks(3);
        wait_idle();
        set_regs(32'h08000, 0, 262144, 16, 0);
        add_ticks(1);
        wait_idle();
        set_regs(32'h08000, 0, 262144, 16, 1);
        add_ticks(1);
        wait_idle();
        // largest step jumps past the end, then a tick on a stopped voice
        set_regs(32'hFFFFF, 0, 262144, 16, 2);
        add_ticks(3);
        wait_idle();

        // zero step keeps the position
        set_regs(0, 5, 40, 64, 2);
        add_random(MODE_TRIG);
        add_ticks(2);
        wait_idle();
        // length dropped to zero under a playing voice
        set_regs(0, 5, 40, 0, 2);
        add_ticks(1);
        add_random(MODE_TRIG);
        add_ticks(1);
        wait_idle();

        // whole memory, start at the top frame, end pinned one frame later
        set_regs(32'h10000, TOP_FRAME, 0, 262144, 2);
        add_random(MODE_TRIG);
        add_ticks(3);
        wait_idle();
        set_regs(32'h10000, 0, 0, 262144, 1);
        add_random(MODE_TRIG);
        add_ticks(2);
        wait_idle();
        // end beyond the loaded length: last frame held until the end
        set_regs(32'h0C000, 60, 262144, 64, 2);
        add_random(MODE_TRIG);
        add_ticks(7);
        wait_idle();

        // output held off while the input keeps offering ticks
        set_idling(0, 0);
        set_regs(32'h00100, 0, 64, 64, 2);
        hold_go = 1'b1;
        add_random(MODE_TRIG);
        add_ticks(40);
        wait_idle();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0:       set_idling(0, 0);
                1:       set_idling(64, 0);
                2:       set_idling(0, 64);
                default: set_idling(15, 15);
            endcase
            // regions stay inside the loaded frames
            wide = ($urandom_range(9) == 0);
            case ($urandom_range(4))
                0:       step_v = $urandom_range(32'hFFFFF);
                1:       step_v = $urandom_range(1, 32'hFFFF);
                2:       step_v = $urandom_range(32'h10000, 32'h30000);
                3:       step_v = 32'h4000 * $urandom_range(1, 8);
                default: step_v = $urandom_range(1, 32'h1FFFF);
            endcase
            if (wide) begin
                len_v   = 262144;
                start_v = $urandom_range(60);
                end_v   = $urandom_range(64);
            end else begin
                len_v   = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, LOADED_FRAMES - 1);
                start_v = $urandom_range(70);
                end_v   = ($urandom_range(3) == 0) ? 262144 : $urandom_range(80);
            end
            chan_v = ($urandom_range(3) == 0) ? $urandom_range(3) : 2;
            set_regs(step_v, start_v, end_v, len_v, chan_v);

            budget = 0;
            while (budget < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    k = $urandom_range(1, 12);
                    add_random(MODE_TRIG);
                    repeat (k) begin
                        if ($urandom_range(9) == 0) begin
                            add_loaded_frame();
                            budget++;
                        end
                        add_ticks(1);
                    end
                    budget += k + 1;
                end else if (pick < 87) begin
                    add_random(MODE_LOAD);
                    budget++;
                end else if (pick < 93) begin
                    add_random(MODE_SPARE);
                end else begin
                    add_ticks(1);
                    budget++;
                end
            end
            wait_idle();
        end

        $display("checked %0d results: %0d ticks, %0d triggers, %0d loads, %0d region ends",
                 n_checked, n_ticks, n_triggers, n_loads, n_region_ends);
        $display("%0d register writes over %0d random settings and the directed corners",
                 n_reg_writes, RANDOM_PHASES);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: interpolating_sample_player.f
+incdir+hw/rtl
hw/rtl/isp_pkg.sv
hw/rtl/isp_in_if.sv
hw/rtl/isp_out_if.sv
hw/rtl/isp_cfg_if.sv
hw/rtl/interpolating_sample_player.sv
test/interpolating_sample_player_tb.sv
